[design/ecr_pkg.sv]
package ecr_pkg;

  localparam int MAX_EDGES = 65536;
  localparam int MAP_WORDS = (MAX_EDGES + 63) / 64;
  localparam int ADDR_W    = $clog2(MAP_WORDS);
  localparam int WORD_W    = 64;
  localparam int BIT_W     = $clog2(WORD_W);
  localparam int IDX_W     = 16;
  localparam int CNT_W     = 17;

  localparam logic [63:0] INDEX_MUL = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] COUNT_MUL = 64'h517cc1b727220a95;

  localparam logic FUNC_HIT   = 1'b0;
  localparam logic FUNC_CLEAR = 1'b1;

  typedef struct packed {
    logic                newly_covered;
    logic                index_ignored;
    logic [CNT_W-1:0]    cov_count;
    logic signed [63:0]  signature;
  } ecr_result_t;

endpackage

[design/ecr_in_if.sv]
interface ecr_in_if
  import ecr_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             func;
  logic [IDX_W-1:0] hit_idx;

  modport source (output valid, func, hit_idx, input ready);
  modport sink (input valid, func, hit_idx, output ready);
endinterface

[design/ecr_out_if.sv]
interface ecr_out_if
  import ecr_pkg::*;
();
  logic               valid;
  logic               ready;
  logic               newly_covered;
  logic               index_ignored;
  logic [CNT_W-1:0]   cov_count;
  logic signed [63:0] signature;

  modport source (output valid, newly_covered, index_ignored, cov_count, signature,
                  input ready);
  modport sink (input valid, newly_covered, index_ignored, cov_count, signature,
                output ready);
endinterface

[design/edge_coverage_recorder_core.sv]
// a hit beat runs through S_READ, S_M1, S_M2, S_M3, S_M4 and S_OUT, an ignored hit skips to
// S_M2, a clear beat sweeps the whole map first; the next beat is taken in the cycle after the
// result is loaded, so beats never overlap in the steps of the shared 17x32 multiplier
// reset: synchronous active-low; afterwards the hit map is swept to zero, one word per
// cycle (MAP_WORDS = 1024 words), before the first beat is taken; edge_count resets to 0
module edge_coverage_recorder_core
  import ecr_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  ecr_in_if.sink           in_ch,
  ecr_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;  // map word back from ram, test and set
  localparam logic [2:0] S_M1    = 3'd2;  // index * low half of INDEX_MUL done
  localparam logic [2:0] S_M2    = 3'd3;  // index product complete, fold into sum
  localparam logic [2:0] S_M3    = 3'd4;  // count * low half of COUNT_MUL done
  localparam logic [2:0] S_M4    = 3'd5;  // signature complete
  localparam logic [2:0] S_OUT   = 3'd6;  // hand result to the output register
  localparam logic [2:0] S_CLEAR = 3'd7;  // zeroing sweep over the map

  localparam logic [CNT_W-1:0]  CNT_MAX   = '1;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(MAP_WORDS - 1);

  logic [2:0]        state_r, state_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              new_r, new_nxt;
  logic              ign_r, ign_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [63:0]       sum_r, sum_nxt;
  logic [63:0]       acc_r, acc_nxt;
  logic [63:0]       sig_r, sig_nxt;
  logic [48:0]       prod_r;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic              clr_item_r, clr_item_nxt;
  logic [CNT_W-1:0]  edge_count_r, edge_count_nxt;
  logic              out_valid_r, out_valid_nxt;
  ecr_result_t       out_r, out_nxt;

  // map memory port
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // shared multiplier, 17 x 32 bits, result registered in prod_r
  logic [CNT_W-1:0]  mul_a;
  logic [31:0]       mul_b;
  logic [48:0]       mul_p;

  logic              hit_ignored;
  logic              bit_set;
  logic [BIT_W-1:0]  bit_pos;

  ecr_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign mul_p = {32'b0, mul_a} * {17'b0, mul_b};

  // out-of-range check against the configured limit and the map size
  assign hit_ignored = ({1'b0, in_ch.hit_idx} >= edge_count_r) ||
                       (32'(in_ch.hit_idx) >= MAX_EDGES);

  assign bit_pos = idx_r[BIT_W-1:0];
  assign bit_set = ram_rdata[bit_pos];

  assign in_ch.ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    new_nxt        = new_r;
    ign_nxt        = ign_r;
    cnt_nxt        = cnt_r;
    sum_nxt        = sum_r;
    acc_nxt        = acc_r;
    sig_nxt        = sig_r;
    clr_cnt_nxt    = clr_cnt_r;
    clr_item_nxt   = clr_item_r;
    edge_count_nxt = edge_count_r;
    out_nxt        = out_r;
    out_valid_nxt  = out_valid_r;

    ram_we    = 1'b0;
    ram_addr  = ADDR_W'(in_ch.hit_idx >> BIT_W);
    ram_wdata = '0;
    mul_a     = '0;
    mul_b     = '0;

    // output register drains on its own, refilled from S_OUT
    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_we) begin
      edge_count_nxt = cfg_wdata;
    end

    case (state_r)
      S_IDLE: begin
        // ram read for the word is issued here, off the input beat directly
        if (in_ch.valid) begin
          idx_nxt = in_ch.hit_idx;
          new_nxt = 1'b0;
          ign_nxt = 1'b0;
          if (in_ch.func == FUNC_CLEAR) begin
            clr_cnt_nxt  = '0;
            clr_item_nxt = 1'b1;
            state_nxt    = S_CLEAR;
          end else if (hit_ignored) begin
            // nothing changes, just rebuild the current signature
            ign_nxt   = 1'b1;
            state_nxt = S_M2;
          end else begin
            state_nxt = S_READ;
          end
        end
      end
      S_READ: begin
        // read-modify-write of the word; one beat in flight, so no forwarding needed
        ram_addr = ADDR_W'(idx_r >> BIT_W);
        if (!bit_set) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (64'd1 << bit_pos);
          new_nxt   = 1'b1;
          if (cnt_r != CNT_MAX) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        mul_a     = CNT_W'(idx_r);
        mul_b     = INDEX_MUL[31:0];
        state_nxt = S_M1;
      end
      S_M1: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = CNT_W'(idx_r);
        mul_b     = INDEX_MUL[63:32];
        state_nxt = S_M2;
      end
      S_M2: begin
        // index * INDEX_MUL mod 2^64 = low product + (high product << 32)
        if (new_r) begin
          sum_nxt = sum_r ^ (acc_r + {prod_r[31:0], 32'b0});
        end
        mul_a     = cnt_r;
        mul_b     = COUNT_MUL[31:0];
        state_nxt = S_M3;
      end
      S_M3: begin
        acc_nxt   = 64'(prod_r);
        mul_a     = cnt_r;
        mul_b     = COUNT_MUL[63:32];
        state_nxt = S_M4;
      end
      S_M4: begin
        // empty map gives a zero signature
        if (cnt_r == '0) begin
          sig_nxt = '0;
        end else begin
          sig_nxt = sum_r ^ (acc_r + {prod_r[31:0], 32'b0});
        end
        state_nxt = S_OUT;
      end
      S_OUT: begin
        // wait here while the previous result is still held
        if (!out_valid_r || out_ch.ready) begin
          out_nxt.newly_covered = new_r;
          out_nxt.index_ignored = ign_r;
          out_nxt.cov_count     = cnt_r;
          out_nxt.signature     = sig_r;
          out_valid_nxt         = 1'b1;
          state_nxt             = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we      = 1'b1;
        ram_addr    = clr_cnt_r;
        ram_wdata   = '0;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_WORD) begin
          cnt_nxt      = '0;
          sum_nxt      = '0;
          clr_item_nxt = 1'b0;
          // a clear beat still reports; the sweep after reset does not
          state_nxt    = clr_item_r ? S_M2 : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      clr_item_r   <= 1'b0;
      cnt_r        <= '0;
      sum_r        <= '0;
      edge_count_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      clr_cnt_r    <= clr_cnt_nxt;
      clr_item_r   <= clr_item_nxt;
      cnt_r        <= cnt_nxt;
      sum_r        <= sum_nxt;
      edge_count_r <= edge_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    new_r  <= new_nxt;
    ign_r  <= ign_nxt;
    acc_r  <= acc_nxt;
    sig_r  <= sig_nxt;
    prod_r <= mul_p;
    out_r  <= out_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.newly_covered = out_r.newly_covered;
  assign out_ch.index_ignored = out_r.index_ignored;
  assign out_ch.cov_count     = out_r.cov_count;
  assign out_ch.signature     = out_r.signature;

  // a bit newly set in the map must bump the count unless saturated
  a_count_bump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ && ram_we && cnt_r != CNT_MAX)
      |=> (cnt_r == $past(cnt_r) + 17'd1))
    else $error("covered count not bumped on new edge");

  // an empty map always reports a zero signature
  a_zero_sig: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.cov_count == '0) |-> (out_r.signature == '0))
    else $error("nonzero signature with zero coverage");

  // an ignored hit can never set a bit
  a_new_vs_ignored: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.newly_covered && out_r.index_ignored))
    else $error("result both new and ignored");

endmodule

[design/ecr_ram.sv]
module ecr_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // single port, read returns old data on a write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
